// ===== design/heartbeat_peak_bpm_detector_assert.svh =====
// Assertion macros for the heartbeat peak / BPM detector.
// Used by heartbeat_peak_bpm_detector.sv; needs clk and arst_n in scope.
`ifndef HEARTBEAT_PEAK_BPM_DETECTOR_ASSERT_SVH
`define HEARTBEAT_PEAK_BPM_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define HBPM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HBPM_NEVER(lbl, expr, msg) \
	`HBPM_ASSERT(lbl, !(expr), msg)
`else
`define HBPM_ASSERT(lbl, prop, msg)
`define HBPM_NEVER(lbl, expr, msg)
`endif
`endif

// ===== design/hbpm_pkg.sv =====
// Shared constants, control-word type and microcode ROM for the heartbeat
// peak / BPM detector. No dependencies.
`default_nettype none
package hbpm_pkg;

	localparam int SAMPLE_BITS_DEF = 12;
	localparam int SAMPLE_W = 12;
	localparam int SMP_EXT_W = 16;
	localparam int PERIOD_W = 10;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd60;
	localparam int SCALE_W = 14;
	localparam int REL_W = 10;
	localparam int FALL_W = 12;
	localparam int INT_W = 20;
	localparam int BPM_W = 10;
	localparam int DIGIT_W = 4;
	localparam int REM_W = 7;
	localparam int TRK_W = 32;
	localparam int MX_W = 34;
	localparam int DVD_W = 16;
	localparam int DVS_W = 20;
	localparam int MUL_W = 32;

	localparam logic [BPM_W-1:0] BPM_MAX = 10'd999;
	localparam logic [DVD_W-1:0] K_SCALE = 16'd10000;
	localparam logic [DVD_W-1:0] K_REL = 16'd1000;
	localparam logic [DVD_W-1:0] K_FALL = 16'd3000;
	localparam logic [DVD_W-1:0] K_BPM = 16'd60000;

	// floor(n/5) = (n * RECIP5) >> RECIP5_SH for any 32-bit n
	localparam logic [MUL_W-1:0] RECIP5 = 32'hCCCC_CCCD;
	localparam int RECIP5_SH = 34;
	// decimal split of 0..999
	localparam int DIV100_MUL = 41;
	localparam int DIV100_SH = 12;
	localparam int DIV10_MUL = 205;
	localparam int DIV10_SH = 11;

	localparam int PC_W = 5;
	localparam int OP_W = 4;
	localparam int COND_W = 3;

	localparam logic [OP_W-1:0] OP_NOP = 4'd0;
	localparam logic [OP_W-1:0] OP_DIV_S = 4'd1;
	localparam logic [OP_W-1:0] OP_WR_S = 4'd2;
	localparam logic [OP_W-1:0] OP_DIV_R = 4'd3;
	localparam logic [OP_W-1:0] OP_WR_R = 4'd4;
	localparam logic [OP_W-1:0] OP_DIV_F = 4'd5;
	localparam logic [OP_W-1:0] OP_WR_F = 4'd6;
	localparam logic [OP_W-1:0] OP_MUL_X = 4'd7;
	localparam logic [OP_W-1:0] OP_MUL_5 = 4'd8;
	localparam logic [OP_W-1:0] OP_REBASE = 4'd9;
	localparam logic [OP_W-1:0] OP_THRESH = 4'd10;
	localparam logic [OP_W-1:0] OP_PEAK = 4'd11;
	localparam logic [OP_W-1:0] OP_DIV_B = 4'd12;
	localparam logic [OP_W-1:0] OP_WR_B = 4'd13;
	localparam logic [OP_W-1:0] OP_INT = 4'd14;
	localparam logic [OP_W-1:0] OP_DIGIT = 4'd15;

	localparam logic [COND_W-1:0] C_NEXT = 3'd0;
	localparam logic [COND_W-1:0] C_JUMP = 3'd1;
	localparam logic [COND_W-1:0] C_IN_WAIT = 3'd2;
	localparam logic [COND_W-1:0] C_DIV_BUSY = 3'd3;
	localparam logic [COND_W-1:0] C_NO_BEAT = 3'd4;
	localparam logic [COND_W-1:0] C_INT_ZERO = 3'd5;
	localparam logic [COND_W-1:0] C_OUT_BUSY = 3'd6;

	// digit ops share one opcode; a sub-field picks the step
	localparam int SUB_W = 2;
	localparam logic [SUB_W-1:0] SUB_H = 2'd0;
	localparam logic [SUB_W-1:0] SUB_R = 2'd1;
	localparam logic [SUB_W-1:0] SUB_T = 2'd2;
	localparam logic [SUB_W-1:0] SUB_OUT = 2'd3;

	localparam logic [PC_W-1:0] ST_IDLE = 5'd0;
	localparam logic [PC_W-1:0] ST_DIV_S = 5'd1;
	localparam logic [PC_W-1:0] ST_WR_S = 5'd2;
	localparam logic [PC_W-1:0] ST_DIV_R = 5'd3;
	localparam logic [PC_W-1:0] ST_WR_R = 5'd4;
	localparam logic [PC_W-1:0] ST_DIV_F = 5'd5;
	localparam logic [PC_W-1:0] ST_WR_F = 5'd6;
	localparam logic [PC_W-1:0] ST_MUL_X = 5'd7;
	localparam logic [PC_W-1:0] ST_MUL_5 = 5'd8;
	localparam logic [PC_W-1:0] ST_REBASE = 5'd9;
	localparam logic [PC_W-1:0] ST_THRESH = 5'd10;
	localparam logic [PC_W-1:0] ST_PEAK = 5'd11;
	localparam logic [PC_W-1:0] ST_BEAT_CHK = 5'd12;
	localparam logic [PC_W-1:0] ST_DIV_B = 5'd13;
	localparam logic [PC_W-1:0] ST_WR_B = 5'd14;
	localparam logic [PC_W-1:0] ST_INT = 5'd15;
	localparam logic [PC_W-1:0] ST_DIG_H = 5'd16;
	localparam logic [PC_W-1:0] ST_DIG_R = 5'd17;
	localparam logic [PC_W-1:0] ST_DIG_T = 5'd18;
	localparam logic [PC_W-1:0] ST_OUT = 5'd19;
	localparam logic [PC_W-1:0] ST_RET = 5'd20;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SUB_W-1:0]  sub;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
	} ucode_t;

	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{op: OP_NOP, sub: SUB_H, cond: C_JUMP, target: ST_IDLE};
		unique case (pc)
			ST_IDLE:     w = '{OP_NOP, SUB_H, C_IN_WAIT, ST_IDLE};
			ST_DIV_S:    w = '{OP_DIV_S, SUB_H, C_NEXT, ST_IDLE};
			ST_WR_S:     w = '{OP_WR_S, SUB_H, C_DIV_BUSY, ST_WR_S};
			ST_DIV_R:    w = '{OP_DIV_R, SUB_H, C_NEXT, ST_IDLE};
			ST_WR_R:     w = '{OP_WR_R, SUB_H, C_DIV_BUSY, ST_WR_R};
			ST_DIV_F:    w = '{OP_DIV_F, SUB_H, C_NEXT, ST_IDLE};
			ST_WR_F:     w = '{OP_WR_F, SUB_H, C_DIV_BUSY, ST_WR_F};
			ST_MUL_X:    w = '{OP_MUL_X, SUB_H, C_NEXT, ST_IDLE};
			ST_MUL_5:    w = '{OP_MUL_5, SUB_H, C_NEXT, ST_IDLE};
			ST_REBASE:   w = '{OP_REBASE, SUB_H, C_NEXT, ST_IDLE};
			ST_THRESH:   w = '{OP_THRESH, SUB_H, C_NEXT, ST_IDLE};
			ST_PEAK:     w = '{OP_PEAK, SUB_H, C_NEXT, ST_IDLE};
			ST_BEAT_CHK: w = '{OP_NOP, SUB_H, C_NO_BEAT, ST_INT};
			ST_DIV_B:    w = '{OP_DIV_B, SUB_H, C_INT_ZERO, ST_INT};
			ST_WR_B:     w = '{OP_WR_B, SUB_H, C_DIV_BUSY, ST_WR_B};
			ST_INT:      w = '{OP_INT, SUB_H, C_NEXT, ST_IDLE};
			ST_DIG_H:    w = '{OP_DIGIT, SUB_H, C_NEXT, ST_IDLE};
			ST_DIG_R:    w = '{OP_DIGIT, SUB_R, C_NEXT, ST_IDLE};
			ST_DIG_T:    w = '{OP_DIGIT, SUB_T, C_NEXT, ST_IDLE};
			ST_OUT:      w = '{OP_DIGIT, SUB_OUT, C_OUT_BUSY, ST_OUT};
			ST_RET:      w = '{OP_NOP, SUB_H, C_JUMP, ST_IDLE};
			default:     w = '{OP_NOP, SUB_H, C_JUMP, ST_IDLE};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== design/hbpm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the BPM detector.
// Depends on hbpm_pkg for default widths.
`default_nettype none
module hbpm_div #(
	parameter int DVD_W = hbpm_pkg::DVD_W,
	parameter int DVS_W = hbpm_pkg::DVS_W
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire [DVD_W-1:0]       dividend,
	input  wire [DVS_W-1:0]       divisor,
	output logic                  busy,
	output logic [DVD_W-1:0]      quotient
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W+1:0] diff;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign diff = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DVD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[DVS_W+1]) begin
				rem_q <= diff[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== design/heartbeat_peak_bpm_detector.sv =====
// Heartbeat peak detector with BPM output: a microcoded sequencer over a small datapath.
// Depends on hbpm_pkg, hbpm_div and heartbeat_peak_bpm_detector_assert.svh.
//
// One sample in, one result out. Each sample is scaled by 10000/period, compared against
// a tracked maximum with hysteresis, and on the first sample of each peak the interval
// since the previous beat gives BPM = 60000/interval (saturated to 999, split into digits).
// Every sample uses the one shared restoring divider three times, and a beat with a nonzero
// interval uses it a fourth time; the sequencer waits for each division. in_ready is high
// only while the sequencer sits in its idle step; a finished result waits in the output
// register and the next sample is accepted meanwhile.
// sample_period_ms (reset 60, 0 acts as 1) is written with cfg_wr_en, no wait.
`default_nettype none
`include "heartbeat_peak_bpm_detector_assert.svh"
module heartbeat_peak_bpm_detector #(
	parameter int SAMPLE_BITS = hbpm_pkg::SAMPLE_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_wr_en,
	input  wire  [hbpm_pkg::PERIOD_W-1:0]       cfg_wr_data,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [hbpm_pkg::SAMPLE_W-1:0]       sample,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic                                beat,
	output logic [hbpm_pkg::BPM_W-1:0]          bpm,
	output logic                                zero_interval,
	output logic [hbpm_pkg::DIGIT_W-1:0]        hundreds,
	output logic [hbpm_pkg::DIGIT_W-1:0]        tens,
	output logic [hbpm_pkg::DIGIT_W-1:0]        ones
);
	localparam int XW = SAMPLE_BITS + hbpm_pkg::SCALE_W;
	localparam int X4W = XW + 2;
	localparam int MX_W = hbpm_pkg::MX_W;
	localparam int TRK_W = hbpm_pkg::TRK_W;
	localparam int MUL_W = hbpm_pkg::MUL_W;
	localparam int BPM_W = hbpm_pkg::BPM_W;
	localparam int INT_W = hbpm_pkg::INT_W;
	localparam int REM_W = hbpm_pkg::REM_W;
	localparam int DIGIT_W = hbpm_pkg::DIGIT_W;
	localparam int HPROD_W = BPM_W + 7;
	localparam int TPROD_W = REM_W + 8;

	// sequencer
	logic [hbpm_pkg::PC_W-1:0] pc_q;
	hbpm_pkg::ucode_t          ctl;
	logic                      jump;
	logic                      out_busy;
	logic                      accept;

	// architectural state
	logic [hbpm_pkg::PERIOD_W-1:0] period_q;
	logic [hbpm_pkg::PERIOD_W-1:0] p_eff;
	logic [TRK_W-1:0]              tracked_q;
	logic                          in_peak_q;
	logic [INT_W-1:0]              interval_q;
	logic [BPM_W-1:0]              held_q;

	// working registers
	logic [SAMPLE_BITS-1:0]            smp_q;
	logic [hbpm_pkg::SMP_EXT_W-1:0]    smp_ext;
	logic [hbpm_pkg::SCALE_W-1:0]      s_q;
	logic [hbpm_pkg::REL_W-1:0]        r_q;
	logic [hbpm_pkg::FALL_W-1:0]       f_q;
	logic [XW-1:0]                     x_q;
	logic [X4W-1:0]                    x4;
	logic signed [MX_W-1:0]            x_s;
	logic signed [MX_W-1:0]            x4_s;
	logic signed [MX_W-1:0]            mx_q;
	logic signed [MX_W-1:0]            mx_n;
	logic signed [MX_W-1:0]            lo_rel_q;
	logic signed [MX_W-1:0]            lo_fall_q;
	logic [2*MUL_W-1:0]                prod_q;
	logic                              beat_q;
	logic                              zflag_q;
	logic [DIGIT_W-1:0]                h_q;
	logic [REM_W-1:0]                  rem_q;
	logic [DIGIT_W-1:0]                t_q;
	logic [HPROD_W-1:0]                hprod;
	logic [TPROD_W-1:0]                tprod;
	logic [INT_W:0]                    int_sum;

	// divider
	logic                          div_start;
	logic                          div_busy;
	logic [hbpm_pkg::DVD_W-1:0]    div_dvd;
	logic [hbpm_pkg::DVS_W-1:0]    div_dvs;
	logic [hbpm_pkg::DVD_W-1:0]    div_q;

	// output register
	logic                out_valid_q;
	logic                beat_o_q;
	logic                zflag_o_q;
	logic [BPM_W-1:0]    bpm_o_q;
	logic [DIGIT_W-1:0]  hund_o_q;
	logic [DIGIT_W-1:0]  tens_o_q;
	logic [DIGIT_W-1:0]  ones_o_q;

	assign ctl = hbpm_pkg::ucode(pc_q);
	assign in_ready = (pc_q == hbpm_pkg::ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_busy = out_valid_q && !out_ready;
	assign p_eff = (period_q == '0) ? hbpm_pkg::PERIOD_W'(1) : period_q;
	assign smp_ext = hbpm_pkg::SMP_EXT_W'(sample);

	always_comb begin
		unique case (ctl.cond)
			hbpm_pkg::C_NEXT:     jump = 1'b0;
			hbpm_pkg::C_JUMP:     jump = 1'b1;
			hbpm_pkg::C_IN_WAIT:  jump = !in_valid;
			hbpm_pkg::C_DIV_BUSY: jump = div_busy;
			hbpm_pkg::C_NO_BEAT:  jump = !beat_q;
			hbpm_pkg::C_INT_ZERO: jump = (interval_q == '0);
			hbpm_pkg::C_OUT_BUSY: jump = out_busy;
			default:              jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= hbpm_pkg::ST_IDLE;
		end else if (jump) begin
			pc_q <= ctl.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_dvd = hbpm_pkg::K_SCALE;
		div_dvs = hbpm_pkg::DVS_W'(p_eff);
		unique case (ctl.op)
			hbpm_pkg::OP_DIV_S: begin
				div_start = 1'b1;
			end
			hbpm_pkg::OP_DIV_R: begin
				div_start = 1'b1;
				div_dvd = hbpm_pkg::K_REL;
			end
			hbpm_pkg::OP_DIV_F: begin
				div_start = 1'b1;
				div_dvd = hbpm_pkg::K_FALL;
			end
			hbpm_pkg::OP_DIV_B: begin
				div_start = (interval_q != '0);
				div_dvd = hbpm_pkg::K_BPM;
				div_dvs = interval_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	hbpm_div #(
		.DVD_W(hbpm_pkg::DVD_W),
		.DVS_W(hbpm_pkg::DVS_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(div_dvs),
		.busy(div_busy),
		.quotient(div_q)
	);

	assign x4 = {x_q, 2'b00};
	assign x_s = $signed(MX_W'(x_q));
	assign x4_s = $signed(MX_W'(x4));
	assign hprod = HPROD_W'(held_q) * HPROD_W'(hbpm_pkg::DIV100_MUL);
	assign tprod = TPROD_W'(rem_q) * TPROD_W'(hbpm_pkg::DIV10_MUL);
	assign int_sum = {1'b0, interval_q} + (INT_W + 1)'(p_eff);

	always_comb begin
		if (x_s > lo_rel_q) begin
			mx_n = (x_s > mx_q) ? x_s : mx_q;
		end else if (x_s < lo_fall_q) begin
			mx_n = lo_rel_q;
		end else begin
			mx_n = mx_q;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= hbpm_pkg::PERIOD_RST;
			tracked_q <= '0;
			in_peak_q <= 1'b0;
			interval_q <= '0;
			held_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				period_q <= cfg_wr_data;
			end
			unique case (ctl.op)
				hbpm_pkg::OP_PEAK: begin
					tracked_q <= mx_n[TRK_W-1:0];
					if (x_s > lo_rel_q) begin
						in_peak_q <= 1'b1;
					end else if (x_s < lo_fall_q) begin
						in_peak_q <= 1'b0;
					end
				end
				hbpm_pkg::OP_WR_B: begin
					if (!div_busy) begin
						held_q <= (div_q > hbpm_pkg::DVD_W'(hbpm_pkg::BPM_MAX)) ?
							hbpm_pkg::BPM_MAX : div_q[BPM_W-1:0];
					end
				end
				hbpm_pkg::OP_INT: begin
					if (beat_q) begin
						interval_q <= INT_W'(p_eff);
					end else if (int_sum[INT_W]) begin
						interval_q <= '1;
					end else begin
						interval_q <= int_sum[INT_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= smp_ext[SAMPLE_BITS-1:0];
			beat_q <= 1'b0;
			zflag_q <= 1'b0;
		end
		unique case (ctl.op)
			hbpm_pkg::OP_WR_S: s_q <= div_q[hbpm_pkg::SCALE_W-1:0];
			hbpm_pkg::OP_WR_R: r_q <= div_q[hbpm_pkg::REL_W-1:0];
			hbpm_pkg::OP_WR_F: f_q <= div_q[hbpm_pkg::FALL_W-1:0];
			hbpm_pkg::OP_MUL_X: begin
				x_q <= XW'(smp_q) * XW'(s_q);
				mx_q <= $signed({{(MX_W - TRK_W){tracked_q[TRK_W-1]}}, tracked_q});
			end
			hbpm_pkg::OP_MUL_5: begin
				prod_q <= (2 * MUL_W)'(MUL_W'(x4)) * (2 * MUL_W)'(hbpm_pkg::RECIP5);
			end
			hbpm_pkg::OP_REBASE: begin
				if (x4_s < mx_q) begin
					mx_q <= $signed(MX_W'(prod_q >> hbpm_pkg::RECIP5_SH));
				end
			end
			hbpm_pkg::OP_THRESH: begin
				lo_rel_q <= mx_q - $signed(MX_W'(r_q));
				lo_fall_q <= mx_q - $signed(MX_W'(f_q));
			end
			hbpm_pkg::OP_PEAK: begin
				if (x_s > lo_rel_q) begin
					beat_q <= !in_peak_q;
				end
			end
			hbpm_pkg::OP_DIV_B: begin
				zflag_q <= (interval_q == '0);
			end
			hbpm_pkg::OP_DIGIT: begin
				unique case (ctl.sub)
					hbpm_pkg::SUB_H: h_q <= DIGIT_W'(hprod >> hbpm_pkg::DIV100_SH);
					hbpm_pkg::SUB_R: rem_q <= REM_W'(held_q - BPM_W'(h_q) * BPM_W'(100));
					hbpm_pkg::SUB_T: t_q <= DIGIT_W'(tprod >> hbpm_pkg::DIV10_SH);
					hbpm_pkg::SUB_OUT: begin
						if (!out_busy) begin
							beat_o_q <= beat_q;
							zflag_o_q <= zflag_q;
							bpm_o_q <= held_q;
							hund_o_q <= h_q;
							tens_o_q <= t_q;
							ones_o_q <= DIGIT_W'(rem_q - REM_W'(t_q) * REM_W'(10));
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == hbpm_pkg::OP_DIGIT && ctl.sub == hbpm_pkg::SUB_OUT &&
			!out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign beat = beat_o_q;
	assign zero_interval = zflag_o_q;
	assign bpm = bpm_o_q;
	assign hundreds = hund_o_q;
	assign tens = tens_o_q;
	assign ones = ones_o_q;

	`HBPM_ASSERT(a_accept_leaves_idle, accept |=> !in_ready, "sequencer stayed idle on transfer")
	`HBPM_NEVER(a_div_restart, div_start && div_busy, "divider restarted while busy")
	`HBPM_NEVER(a_bpm_range, held_q > hbpm_pkg::BPM_MAX, "held BPM above 999")
	`HBPM_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(pc_q == hbpm_pkg::ST_OUT), "result raised outside output step")
endmodule
`default_nettype wire

// ===== tb/sv/tb_heartbeat_peak_bpm_detector.sv =====
`timescale 1ns / 100ps
// Self-checking bench for heartbeat_peak_bpm_detector: directed and random pulse traces over
// several sample periods, readings predicted in-bench and compared field by field.
// Depends on hbpm_pkg and the detector RTL only.
module tb_heartbeat_peak_bpm_detector;

	localparam int SCALE_NUM    = 10000;
	localparam int RELEASE_NUM  = 1000;
	localparam int FALL_NUM     = 3000;
	localparam int RATE_NUM     = 60000;
	localparam int BPM_CAP      = 999;
	localparam int INTERVAL_CAP = (1 << hbpm_pkg::INT_W) - 1;
	localparam int SAMPLE_TOP   = (1 << hbpm_pkg::SAMPLE_W) - 1;
	localparam int SEGMENTS     = 4;
	localparam int SEG_ITEMS    = 140;
	localparam int FLAT_ITEMS   = 1060;
	localparam int SETTLE_CYCLES = 200;
	localparam int LIMIT_NS     = 16_000_000;

	typedef struct {
		logic                           beat;
		logic [hbpm_pkg::BPM_W-1:0]     bpm;
		logic                           zero_int;
		logic [hbpm_pkg::DIGIT_W-1:0]   hund;
		logic [hbpm_pkg::DIGIT_W-1:0]   tens_d;
		logic [hbpm_pkg::DIGIT_W-1:0]   ones_d;
	} bpm_reading_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               cfg_wr_en = 1'b0;
	logic [hbpm_pkg::PERIOD_W-1:0]      cfg_wr_data = '0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic [hbpm_pkg::SAMPLE_W-1:0]      sample = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic                               beat;
	logic [hbpm_pkg::BPM_W-1:0]         bpm;
	logic                               zero_interval;
	logic [hbpm_pkg::DIGIT_W-1:0]       hundreds;
	logic [hbpm_pkg::DIGIT_W-1:0]       tens;
	logic [hbpm_pkg::DIGIT_W-1:0]       ones;

	// predicted detector state
	logic [hbpm_pkg::PERIOD_W-1:0]      period_ms = hbpm_pkg::PERIOD_RST;
	int                                 tracked_max = 0;
	bit                                 in_peak = 1'b0;
	int                                 interval_ms = 0;
	int                                 held_bpm = 0;

	logic [hbpm_pkg::SAMPLE_W-1:0]      samples_pending[$];
	bpm_reading_t                       readings_due[$];
	int                                 trace[$];

	int                                 mismatches = 0;
	int                                 readings_seen = 0;
	int                                 burst_left = 1;
	int                                 gap_left = 0;
	int                                 gap_pick;
	int                                 run_left = 0;
	int                                 hold_left = 0;
	bit                                 hold_armed = 1'b0;
	bit                                 rx_open = 1'b0;
	bpm_reading_t                       want;

	heartbeat_peak_bpm_detector u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.beat          (beat),
		.bpm           (bpm),
		.zero_interval (zero_interval),
		.hundreds      (hundreds),
		.tens          (tens),
		.ones          (ones)
	);

	always #2 clk = ~clk;

	function automatic bpm_reading_t compute_bpm_reading(input logic [hbpm_pkg::SAMPLE_W-1:0] smp);
		bpm_reading_t r;
		int p;
		int q;
		longint x;
		longint rel;
		longint fall;
		longint mx;
		p = (period_ms == 0) ? 1 : int'(period_ms);
		x = longint'(smp) * (SCALE_NUM / p);
		rel = RELEASE_NUM / p;
		fall = FALL_NUM / p;
		mx = tracked_max;
		r.beat = 1'b0;
		r.zero_int = 1'b0;
		if (4 * x < mx)
			mx = (4 * x) / 5;
		if (x > mx - rel) begin
			if (x > mx)
				mx = x;
			r.beat = !in_peak;
			in_peak = 1'b1;
		end else if (x < mx - fall) begin
			in_peak = 1'b0;
			mx = mx - rel;
		end
		tracked_max = int'(mx);
		if (r.beat) begin
			if (interval_ms == 0) begin
				r.zero_int = 1'b1;
			end else begin
				q = RATE_NUM / interval_ms;
				held_bpm = (q > BPM_CAP) ? BPM_CAP : q;
			end
			interval_ms = 0;
		end
		interval_ms += p;
		if (interval_ms > INTERVAL_CAP)
			interval_ms = INTERVAL_CAP;
		r.bpm = hbpm_pkg::BPM_W'(held_bpm);
		r.hund = hbpm_pkg::DIGIT_W'(held_bpm / 100);
		r.tens_d = hbpm_pkg::DIGIT_W'((held_bpm / 10) % 10);
		r.ones_d = hbpm_pkg::DIGIT_W'(held_bpm % 10);
		return r;
	endfunction

	task automatic check_field(input string name, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
			mismatches++;
		end
	endtask

	// sender: bursts of samples separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				readings_due.push_back(compute_bpm_reading(sample));
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (samples_pending.size() != 0) begin
					in_valid <= 1'b1;
					sample <= samples_pending.pop_front();
					burst_left--;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
							: $urandom_range(1, 8);
						gap_pick = $urandom_range(0, 9);
						gap_left = (gap_pick < 4) ? 0 : (gap_pick < 7) ? $urandom_range(1, 12)
							: $urandom_range(13, 120);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result transfer, stalls in runs, sometimes holds off long
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (readings_due.size() == 0) begin
					$error("result transfer with no reading outstanding");
					mismatches++;
				end else begin
					want = readings_due.pop_front();
					check_field("beat", want.beat, beat);
					check_field("bpm", want.bpm, bpm);
					check_field("zero_interval", want.zero_int, zero_interval);
					check_field("hundreds", want.hund, hundreds);
					check_field("tens", want.tens_d, tens);
					check_field("ones", want.ones_d, ones);
				end
				readings_seen++;
				if (readings_seen % 500 == 250)
					hold_armed = 1'b1;
			end
			if (hold_armed && samples_pending.size() >= 8) begin
				hold_armed = 1'b0;
				hold_left = $urandom_range(600, 900);
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					rx_open = !rx_open;
					if (rx_open)
						run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 800)
							: $urandom_range(1, 60);
					else
						run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
							: $urandom_range(1, 6);
				end
				run_left--;
				out_ready <= rx_open;
			end
		end
	end

	task automatic set_period(input logic [hbpm_pkg::PERIOD_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		period_ms = val;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (samples_pending.size() != 0 || in_valid || readings_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic play_trace();
		foreach (trace[i])
			samples_pending.push_back(hbpm_pkg::SAMPLE_W'(trace[i]));
		wait_drained();
	endtask

	// pulse waveforms: baseline plus triangular peak, jitter, and occasional dropouts/clips
	task automatic queue_pulses(input int count);
		int left;
		int beat_len;
		int base;
		int amp;
		int width;
		int jitter;
		int off;
		int v;
		left = count;
		while (left > 0) begin
			beat_len = $urandom_range(2, 30);
			base = $urandom_range(0, 1500);
			amp = $urandom_range(200, SAMPLE_TOP - base);
			width = $urandom_range(1, beat_len - 1);
			jitter = $urandom_range(0, 60);
			for (int k = 0; k < beat_len && left > 0; k++) begin
				v = base;
				if (k <= width) begin
					off = 2 * k - width;
					if (off < 0)
						off = -off;
					v = base + amp * (width - off) / width;
				end
				v = v + int'($urandom_range(0, 2 * jitter)) - jitter;
				if ($urandom_range(0, 15) == 0) begin
					case ($urandom_range(0, 2))
						0: v = 0;
						1: v = SAMPLE_TOP;
						default: v = $urandom_range(0, SAMPLE_TOP);
					endcase
				end
				if (v < 0)
					v = 0;
				if (v > SAMPLE_TOP)
					v = SAMPLE_TOP;
				samples_pending.push_back(hbpm_pkg::SAMPLE_W'(v));
				left--;
			end
		end
	endtask

	initial begin
		int pick;
		int flat;
		logic [hbpm_pkg::PERIOD_W-1:0] per;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset period; first beat lands on a zero interval
		trace = '{4095, 3000, 4095, 0, 2730, 1365, 2048, 1};
		play_trace();
		// period 0 acts as 1: beats two samples apart saturate bpm
		set_period(0);
		trace = '{4095, 3000, 4095, 3000, 4095};
		play_trace();
		set_period(1);
		trace = '{2048, 1024, 2048};
		play_trace();
		set_period(1023);
		trace = '{4095, 3000, 4095, 2730, 1365};
		play_trace();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: per = 0;
				1: per = 1;
				2: per = 1000;
				3: per = 1023;
				4, 5, 6, 7: per = hbpm_pkg::PERIOD_W'($urandom_range(20, 120));
				default: per = hbpm_pkg::PERIOD_W'($urandom_range(2, 999));
			endcase
			set_period(per);
			if ($urandom_range(0, 4) == 0) begin
				repeat (SEG_ITEMS)
					samples_pending.push_back(hbpm_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_TOP)));
			end else begin
				queue_pulses(SEG_ITEMS);
			end
			wait_drained();
		end

		// flat line long enough to saturate the interval, then one release and one beat
		set_period(1000);
		flat = 2 * $urandom_range(50, 2047);
		repeat (FLAT_ITEMS)
			samples_pending.push_back(hbpm_pkg::SAMPLE_W'(flat));
		samples_pending.push_back(hbpm_pkg::SAMPLE_W'(flat / 2));
		samples_pending.push_back(hbpm_pkg::SAMPLE_W'(flat));
		wait_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
